FILE: rtl/lzrle_pkg.sv
// Package: shared widths, result struct and token decode helpers for the LZ/RLE decompressor.
package lzrle_pkg;

  localparam int unsigned HistDepth = 131072;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned PosW      = 24;
  localparam int unsigned LenW      = 15;
  localparam int unsigned OffW      = 17;
  localparam logic [PosW-1:0] TailLits = PosW'(4);

  // decoder result for one item, handed to the output stage
  typedef struct packed {
    logic              consumed;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              frame_last;
    logic              bad_offset;
    logic              overrun;
    logic              mem_rd;
    logic [HistAw-1:0] rd_addr;
    logic [HistAw-1:0] wr_addr;
  } dec_res_t;

  // header bytes a token needs, from its first byte
  function automatic logic [2:0] hdr_needed(input logic [7:0] b0);
    logic [2:0] n;
    if (!b0[7]) n = 3'd1;
    else if ((b0 & 8'h60) == 8'h00) n = 3'd2;
    else if (!b0[6]) n = 3'd2;
    else if (!b0[5]) n = 3'd3;
    else if (!b0[4]) n = 3'd4;
    else n = 3'd3;
    return n;
  endfunction

  // header byte i counted from the oldest one; zero if not present
  function automatic logic [7:0] hdr_byte(input logic [31:0] hb, input logic [2:0] n,
                                          input logic [1:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (n)
      3'd1: if (i == 2'd0) r = hb[7:0];
      3'd2: begin
        case (i)
          2'd0: r = hb[15:8];
          2'd1: r = hb[7:0];
          default: r = 8'h00;
        endcase
      end
      3'd3: begin
        case (i)
          2'd0: r = hb[23:16];
          2'd1: r = hb[15:8];
          2'd2: r = hb[7:0];
          default: r = 8'h00;
        endcase
      end
      3'd4: begin
        case (i)
          2'd0: r = hb[31:24];
          2'd1: r = hb[23:16];
          2'd2: r = hb[15:8];
          default: r = hb[7:0];
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lzrle_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port with enable.
module lzrle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lzrle_dec.sv
// Decoder state machine: control words, token headers, copy and run sequencing.
module lzrle_dec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         start_req_i,
  input  logic                         in_valid_i,
  input  logic [7:0]                   in_byte_i,
  input  logic [lzrle_pkg::PosW-1:0]   frame_size_i,
  output lzrle_pkg::dec_res_t          res_o
);
  import lzrle_pkg::*;

  typedef enum logic [2:0] {
    PhStart, PhDecide, PhHeader, PhCopy, PhRun, PhDone
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       ctl_q, ctl_d;
  logic [3:0]       left_q, left_d;
  logic [31:0]      hb_q, hb_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [7:0]       run_q, run_d;
  dec_res_t         res;

  always_comb begin
    logic       do_emit, finish, bad;
    logic [7:0] e_byte, b0, b1, b2, b3;
    logic [LenW+1:0] len;
    logic [OffW-1:0] off;
    phase_d = phase_q; pos_d = pos_q; ctl_d = ctl_q; left_d = left_q;
    hb_d = hb_q; hcnt_d = hcnt_q; rem_d = rem_q; off_d = off_q; run_d = run_q;
    res = '0;
    do_emit = 1'b0; finish = 1'b0; e_byte = 8'h00;
    b0 = 8'h00; b1 = 8'h00; b2 = 8'h00; b3 = 8'h00;
    len = '0; off = '0;
    bad = (off_q == '0) || ({{(PosW-OffW){1'b0}}, off_q} > pos_q);
    res.rd_addr = pos_q[HistAw-1:0] - off_q[HistAw-1:0];
    res.wr_addr = pos_q[HistAw-1:0];

    if (start_req_i) begin
      phase_d = PhStart; pos_d = '0; ctl_d = '0; left_d = '0; hb_d = '0;
      hcnt_d = '0; rem_d = '0; off_d = '0; run_d = '0;
    end else begin
      case (phase_q)
        PhStart: begin
          if (in_valid_i) begin
            res.consumed = 1'b1;
            ctl_d = in_byte_i; left_d = 4'd8; phase_d = PhDecide;
          end
        end
        PhDecide: begin
          if (pos_q >= frame_size_i) begin
            phase_d = PhDone;
          end else if (in_valid_i) begin
            res.consumed = 1'b1;
            if (left_q == 4'd0) begin
              ctl_d = in_byte_i; left_d = 4'd8;
            end else if ({1'b0, pos_q} + {1'b0, TailLits} >= {1'b0, frame_size_i}) begin
              left_d = left_q - 4'd1;
              do_emit = 1'b1; e_byte = in_byte_i;
            end else begin
              ctl_d = {ctl_q[6:0], 1'b1};
              left_d = left_q - 4'd1;
              if (!ctl_q[7]) begin
                do_emit = 1'b1; e_byte = in_byte_i;
              end else begin
                hb_d = {24'h0, in_byte_i}; hcnt_d = 3'd1;
                if (hdr_needed(in_byte_i) == 3'd1) finish = 1'b1;
                else phase_d = PhHeader;
              end
            end
          end
        end
        PhHeader: begin
          if (in_valid_i) begin
            res.consumed = 1'b1;
            hb_d = {hb_q[23:0], in_byte_i};
            hcnt_d = hcnt_q + 3'd1;
            if (hcnt_d >= hdr_needed(hdr_byte(hb_d, hcnt_d, 2'd0))) finish = 1'b1;
          end
        end
        PhCopy, PhRun: begin
          if (pos_q >= frame_size_i) begin
            res.overrun = (rem_q != '0);
            rem_d = '0; phase_d = PhDone;
          end else begin
            if (phase_q == PhRun) begin
              e_byte = run_q;
            end else if (bad) begin
              res.bad_offset = 1'b1;
            end else begin
              res.mem_rd = 1'b1;
            end
            if (rem_q != '0) rem_d = rem_q - LenW'(1);
            if (rem_d == '0) phase_d = PhDecide;
            do_emit = 1'b1;
          end
        end
        default: ;
      endcase

      if (finish) begin
        b0 = hdr_byte(hb_d, hcnt_d, 2'd0);
        b1 = hdr_byte(hb_d, hcnt_d, 2'd1);
        b2 = hdr_byte(hb_d, hcnt_d, 2'd2);
        b3 = hdr_byte(hb_d, hcnt_d, 2'd3);
        if (!b0[7]) begin
          len = 17'd3; off = {9'h0, b0};
        end else if ((b0 & 8'h60) == 8'h00) begin
          len = 17'd3; off = {4'h0, b0[4:0], b1};
        end else if (!b0[6]) begin
          len = {14'h0, b0[4:2]} + 17'd4; off = {7'h0, b0[1:0], b1};
        end else if (!b0[5]) begin
          len = {12'h0, b0[4:0]} + 17'd4; off = {1'b0, b1, b2};
        end else if (!b0[4]) begin
          len = {6'h0, b0[3:0], b1[7:1]} + 17'd4; off = {b1[0], b2, b3};
        end else begin
          len = {3'b0, b0[3:0], b1, 2'b00} + 17'd4;
          run_d = b2;
        end
        rem_d = len[LenW-1:0];
        off_d = off;
        hcnt_d = '0; hb_d = '0;
        phase_d = (b0[7:4] == 4'hf) ? PhRun : PhCopy;
      end

      if (do_emit) begin
        res.out_valid = 1'b1;
        res.out_byte = e_byte;
        pos_d = pos_q + PosW'(1);
        if (pos_d >= frame_size_i) begin
          res.frame_last = 1'b1;
          if (rem_d != '0) res.overrun = 1'b1;
          rem_d = '0;
          phase_d = PhDone;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart; pos_q <= '0; ctl_q <= '0; left_q <= '0; hb_q <= '0;
      hcnt_q <= '0; rem_q <= '0; off_q <= '0; run_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d; pos_q <= pos_d; ctl_q <= ctl_d; left_q <= left_d;
      hb_q <= hb_d; hcnt_q <= hcnt_d; rem_q <= rem_d; off_q <= off_d; run_q <= run_d;
    end
  end

  assign res_o = res;

endmodule

FILE: rtl/lz_rle_frame_decompressor.sv
// Top level: decoder, history RAM and the output stage with read forwarding.
//
//  channel | valid/ready           | payload
//  in      | s_valid_i / s_ready_o | start_req_i, in_valid_i, in_byte_i
//  out     | m_valid_o / m_ready_i | consumed_o, out_valid_o, out_byte_o, frame_last_o,
//          |                       | bad_offset_o, overrun_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (frame_size)
//
// One item per cycle while the output is not stalled; the result appears the cycle after acceptance.
// The history RAM is read at acceptance and its data is used in the output stage;
// a read of the byte written that same edge is served from the last-written register.
// Reset clears the control state; history contents are undefined until written.
// A stall on the output holds the output stage and the RAM read data.
module lz_rle_frame_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic        start_req_i,
  input  logic        in_valid_i,
  input  logic [7:0]  in_byte_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic        consumed_o,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_last_o,
  output logic        bad_offset_o,
  output logic        overrun_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);
  import lzrle_pkg::*;

  logic [PosW-1:0]   fsize_q;
  dec_res_t          res;
  logic              accept, advance, fwd;
  logic              b_valid_q, b_fwd_q;
  dec_res_t          b_q;
  logic [7:0]        last_q, rdata, b_byte;

  assign cfg_ready_o = 1'b1;
  assign s_ready_o   = !b_valid_q || m_ready_i;
  assign accept      = s_valid_i && s_ready_o;
  assign advance     = b_valid_q && m_ready_i;
  assign fwd         = advance && b_q.out_valid && (b_q.wr_addr == res.rd_addr);

  lzrle_dec u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .start_req_i  (start_req_i),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .frame_size_i (fsize_q),
    .res_o        (res)
  );

  lzrle_ram #(.Width(8), .Depth(HistDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (advance && b_q.out_valid),
    .waddr_i (b_q.wr_addr),
    .wdata_i (b_byte),
    .re_i    (accept && res.mem_rd),
    .raddr_i (res.rd_addr),
    .rdata_o (rdata)
  );

  assign b_byte = b_q.mem_rd ? (b_fwd_q ? last_q : rdata) : b_q.out_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsize_q   <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) fsize_q <= cfg_data_i;
      if (accept) b_valid_q <= 1'b1;
      else if (advance) b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q     <= res;
      b_fwd_q <= fwd;
    end
    if (advance && b_q.out_valid) last_q <= b_byte;
  end

  assign m_valid_o    = b_valid_q;
  assign consumed_o   = b_q.consumed;
  assign out_valid_o  = b_q.out_valid;
  assign out_byte_o   = b_byte;
  assign frame_last_o = b_q.frame_last;
  assign bad_offset_o = b_q.bad_offset;
  assign overrun_o    = b_q.overrun;

endmodule
